/* rtl/core/tsd_pkg.sv */
`default_nettype none

package tsd_pkg;

   // Stream and history geometry
   localparam int HISTORY    = 5;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int SLOTS      = HISTORY - 1;

   localparam int PIX_W   = 8;
   localparam int CNT_W   = $clog2(HISTORY + 1);
   localparam int SUM_W   = $clog2(HISTORY * (2 ** PIX_W - 1) + 1);
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WARM_W  = $clog2(SLOTS + 1);
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ROW_BITS = SLOTS * PIX_W;
   localparam int AVG_W   = 3;

   // Register file
   localparam int DATA_W    = 32;
   localparam int PADDR_W   = 4;
   localparam int THR_W     = 8;
   localparam int DIM_CFG_W = 11;
   localparam logic [THR_W-1:0]     THR_RESET    = THR_W'(10);
   localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = DIM_CFG_W'(640);
   localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = DIM_CFG_W'(480);

   typedef enum logic [1:0] {
      REG_ENABLE    = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_WIDTH     = 2'd2,
      REG_HEIGHT    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                 enable;
      logic [THR_W-1:0]     threshold;
      logic [DIM_CFG_W-1:0] frame_width;
      logic [DIM_CFG_W-1:0] frame_height;
   } cfg_type;

   // One memory word holds every history slot of one pixel position
   typedef logic [SLOTS-1:0][PIX_W-1:0] row_type;

endpackage

`default_nettype wire

/* rtl/core/temporal_similarity_denoise.sv */
// Each accepted word passes through ST_READ (history read, similarity sum), ST_DIV (the
// bit-serial divider, one quotient bit a cycle) and ST_DONE, which waits for the result
// register to be free; a new word is taken only back in ST_IDLE, one word at a time.
// Reset: synchronous, active high; clears control, position, warm-up and registers.
// The history memory is not cleared; it is filled by the warm-up frames.
`default_nettype none

module temporal_similarity_denoise
   import tsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [PIX_W-1:0]   req_pixel_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [PIX_W-1:0]   rsp_pixel_out,
   output logic      [AVG_W-1:0]   rsp_frames_averaged,
   output logic                    rsp_frame_end,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic      [DATA_W-1:0]  prdata,
   output logic                    pready
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   cfg_type   cfg;
   state_type state_ff, state_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [WARM_W-1:0] warm_ff, warm_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;

   logic [PIX_W-1:0]  pix_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              avg_ff;
   logic              store_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_pixel_ff;
   logic [AVG_W-1:0]  rsp_avg_ff;
   logic              rsp_end_ff;

   logic              accept;
   logic [WDIM_W-1:0] w_eff;
   logic [HDIM_W-1:0] h_eff;
   logic              line_end;
   logic              row_end;
   logic              last;
   logic [ADDR_W-1:0] addr;

   logic [ROW_BITS-1:0] rd_data;
   row_type             rd_row;
   row_type             wr_row;
   logic [SUM_W-1:0]    sum_acc;
   logic [CNT_W-1:0]    cnt_acc;

   logic              div_done;
   logic [PIX_W-1:0]  div_quot;
   logic              out_free;

   tsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Clamp the frame size into the supported range
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = WDIM_W'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_eff = WDIM_W'(MAX_WIDTH);
      end else begin
         w_eff = WDIM_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_eff = HDIM_W'(1);
      end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
         h_eff = HDIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = HDIM_W'(cfg.frame_height);
      end
   end

   assign line_end = (WDIM_W'(col_ff) + WDIM_W'(1)) >= w_eff;
   assign row_end  = (HDIM_W'(row_ff) + HDIM_W'(1)) >= h_eff;
   assign last     = line_end && row_end;
   assign addr     = ADDR_W'(row_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_ff);

   // Advance raster position per word, warm-up and ring slot per enabled frame
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      warm_in   = warm_ff;
      oldest_in = oldest_ff;
      if (accept) begin
         if (line_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         if (cfg.enable && last) begin
            if (warm_ff != WARM_W'(SLOTS)) begin
               warm_in = warm_ff + WARM_W'(1);
            end
            oldest_in = (oldest_ff == SLOT_W'(SLOTS - 1)) ? '0 : oldest_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         warm_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         warm_ff   <= warm_in;
         oldest_ff <= oldest_in;
      end
   end

   // Hold the word and its context while it is worked on
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req_pixel_in;
         addr_ff  <= addr;
         slot_ff  <= oldest_ff;
         avg_ff   <= cfg.enable && (warm_ff == WARM_W'(SLOTS));
         store_ff <= cfg.enable;
         last_ff  <= last;
      end
      if (state_ff == ST_READ) begin
         cnt_ff <= cnt_acc;
      end
   end

   tsd_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   ((state_ff == ST_READ) && store_ff),
      .wr_addr (addr_ff),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign rd_row = row_type'(rd_data);

   // Walk the history newest first, stop at the first dissimilar value
   always_comb begin
      logic             going;
      logic [SLOT_W:0]  pos;
      logic [PIX_W-1:0] val;
      logic [PIX_W-1:0] diff;
      going   = avg_ff;
      sum_acc = SUM_W'(pix_ff);
      cnt_acc = CNT_W'(1);
      for (int k = 0; k < SLOTS; k++) begin
         pos = {1'b0, slot_ff} + (SLOT_W + 1)'(SLOTS - 1 - k);
         if (pos >= (SLOT_W + 1)'(SLOTS)) begin
            pos = pos - (SLOT_W + 1)'(SLOTS);
         end
         val  = rd_row[pos[SLOT_W-1:0]];
         diff = (val > pix_ff) ? val - pix_ff : pix_ff - val;
         if (going && (diff <= cfg.threshold)) begin
            sum_acc = sum_acc + SUM_W'(val);
            cnt_acc = cnt_acc + CNT_W'(1);
         end else begin
            going = 1'b0;
         end
      end
   end

   // Replace the oldest slot with the current pixel
   always_comb begin
      wr_row          = rd_row;
      wr_row[slot_ff] = pix_ff;
   end

   tsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_READ),
      .dividend (sum_acc),
      .divisor  (cnt_acc),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequence one word at a time
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register: load when free, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_pixel_ff <= div_quot;
         rsp_avg_ff   <= (32'(cnt_ff) > 32'(7)) ? AVG_W'(7) : AVG_W'(cnt_ff);
         rsp_end_ff   <= last_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel_out       = rsp_pixel_ff;
   assign rsp_frames_averaged = rsp_avg_ff;
   assign rsp_frame_end       = rsp_end_ff;

endmodule

`default_nettype wire

/* rtl/core/tsd_ram.sv */
`default_nettype none

module tsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/tsd_csr.sv */
`default_nettype none

module tsd_csr
   import tsd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic      [DATA_W-1:0]  prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_hit;

   assign index  = reg_index_type'(paddr[PADDR_W-1:2]);
   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_hit) begin
         case (index)
            REG_ENABLE:    cfg_in.enable       = pwdata[0];
            REG_THRESHOLD: cfg_in.threshold    = pwdata[THR_W-1:0];
            REG_WIDTH:     cfg_in.frame_width  = pwdata[DIM_CFG_W-1:0];
            REG_HEIGHT:    cfg_in.frame_height = pwdata[DIM_CFG_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable       <= 1'b0;
         cfg_ff.threshold    <= THR_RESET;
         cfg_ff.frame_width  <= WIDTH_RESET;
         cfg_ff.frame_height <= HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (index)
         REG_ENABLE:    prdata = DATA_W'(cfg_ff.enable);
         REG_THRESHOLD: prdata = DATA_W'(cfg_ff.threshold);
         REG_WIDTH:     prdata = DATA_W'(cfg_ff.frame_width);
         REG_HEIGHT:    prdata = DATA_W'(cfg_ff.frame_height);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/core/tsd_div.sv */
`default_nettype none

module tsd_div
   import tsd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] dividend,
   input  wire logic [CNT_W-1:0] divisor,
   output logic                  done,
   output logic      [PIX_W-1:0] quotient
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  num_ff, num_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    trial_sub;
   logic              ge;
   logic [CNT_W:0]    twice_rem;
   logic              round_up;

   // One quotient bit a cycle, restoring
   assign trial     = {rem_ff, num_ff[SUM_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign ge        = trial >= {1'b0, div_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         iter_in = ITER_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in  = {num_ff[SUM_W-2:0], ge};
         rem_in  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   // Round half to even
   assign twice_rem = {rem_ff, 1'b0};
   assign round_up  = (twice_rem > {1'b0, div_ff})
                   || ((twice_rem == {1'b0, div_ff}) && num_ff[0]);
   assign quotient  = PIX_W'(num_ff + SUM_W'(round_up));
   assign done      = done_ff;

endmodule

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb
   import tsd_pkg::*;
;

   // Frames that follow warm-up stay inside this rectangle, so every pixel
   // position that is read back has been written in every history slot
   localparam int RECT_W = 8;
   localparam int RECT_H = 4;

   typedef struct {
      logic [PIX_W-1:0] pixel;
      logic [AVG_W-1:0] averaged;
      logic             frame_end;
   } denoise_word_type;

   // Predicts each output word of the denoiser and matches it against the DUT
   class denoise_board;
      bit                enable;
      int unsigned       threshold;
      int unsigned       width_cfg;
      int unsigned       height_cfg;
      int unsigned       warm;
      int unsigned       oldest;
      int unsigned       column;
      int unsigned       row;
      logic [PIX_W-1:0]  history [int unsigned];
      denoise_word_type  awaited_words [$];
      int                failures;

      function new();
         enable     = 1'b0;
         threshold  = 10;
         width_cfg  = 640;
         height_cfg = 480;
         warm       = 0;
         oldest     = 0;
         column     = 0;
         row        = 0;
         failures   = 0;
      endfunction

      function void write_register(reg_index_type idx, int unsigned value);
         case (idx)
            REG_ENABLE:    enable     = value[0];
            REG_THRESHOLD: threshold  = value & 32'hFF;
            REG_WIDTH:     width_cfg  = value & 32'h7FF;
            REG_HEIGHT:    height_cfg = value & 32'h7FF;
            default: ;
         endcase
      endfunction

      // Zero counts as one, anything above the maximum as the maximum
      function int unsigned fit_dim(int unsigned v, int unsigned limit);
         if (v == 0) return 1;
         return (v > limit) ? limit : v;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] pix);
         int unsigned      w, h, base, total, count, k, slot, stored, gap, quo, rem;
         bit               line_end, last;
         denoise_word_type word;
         w        = fit_dim(width_cfg, MAX_WIDTH);
         h        = fit_dim(height_cfg, MAX_HEIGHT);
         line_end = (column + 1 >= w);
         last     = line_end && (row + 1 >= h);
         base     = row * MAX_WIDTH + column;
         count    = 1;
         word.pixel = pix;
         if (oldest >= SLOTS) oldest = 0;
         if (enable) begin
            // Average with stored frames, newest first, until one strays too far
            if (warm >= SLOTS) begin
               total = 32'(pix);
               for (k = 0; k < SLOTS; k++) begin
                  slot   = (oldest + SLOTS - 1 - k) % SLOTS;
                  stored = history.exists(slot * DEPTH + base)
                           ? 32'(history[slot * DEPTH + base]) : 0;
                  gap    = (stored > 32'(pix)) ? stored - 32'(pix) : 32'(pix) - stored;
                  if (gap > threshold) break;
                  total += stored;
                  count++;
               end
               // Round to nearest, ties to even
               quo = total / count;
               rem = total % count;
               if (2 * rem > count || (2 * rem == count && quo[0])) quo++;
               word.pixel = quo[PIX_W-1:0];
            end
            history[oldest * DEPTH + base] = pix;
            if (last) begin
               if (warm < SLOTS) warm++;
               oldest = (oldest + 1) % SLOTS;
            end
         end
         // Advance the raster position whatever the enable
         if (line_end) begin
            column = 0;
            row    = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            column++;
         end
         word.averaged  = AVG_W'((count > 7) ? 7 : count);
         word.frame_end = last;
         awaited_words.push_back(word);
      endfunction

      // Number of words still needed to reach the end of the current frame
      function int unsigned pixels_to_frame_end();
         int unsigned w, h, c, r, n;
         bit          line_end, last;
         w = fit_dim(width_cfg, MAX_WIDTH);
         h = fit_dim(height_cfg, MAX_HEIGHT);
         c = column;
         r = row;
         n = 0;
         do begin
            n++;
            line_end = (c + 1 >= w);
            last     = line_end && (r + 1 >= h);
            if (line_end) begin
               c = 0;
               r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
               c++;
            end
         end while (!last);
         return n;
      endfunction

      function int unsigned waiting();
         return awaited_words.size();
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 200)
               $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_word(logic [PIX_W-1:0] pixel, logic [AVG_W-1:0] averaged,
                               logic frame_end);
         denoise_word_type want;
         if (awaited_words.size() == 0) begin
            failures++;
            if (failures <= 200)
               $display("%0t: unexpected word pixel_out=%0d frames_averaged=%0d frame_end=%0d",
                        $time, pixel, averaged, frame_end);
            return;
         end
         want = awaited_words.pop_front();
         compare_field("pixel_out", want.pixel, pixel);
         compare_field("frames_averaged", 8'(want.averaged), 8'(averaged));
         compare_field("frame_end", 8'(want.frame_end), 8'(frame_end));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PIX_W-1:0]   req_pixel_in = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [PIX_W-1:0]   rsp_pixel_out;
   logic [AVG_W-1:0]   rsp_frames_averaged;
   logic               rsp_frame_end;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   denoise_board       board;
   bit                 steady = 1'b0;
   int                 spread = 4;
   int unsigned        pixels_sent = 0;
   logic [PIX_W-1:0]   scene [RECT_W*RECT_H];

   temporal_similarity_denoise dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_pixel_in        (req_pixel_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_out       (rsp_pixel_out),
      .rsp_frames_averaged (rsp_frames_averaged),
      .rsp_frame_end       (rsp_frame_end),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void new_scene();
      int i, pick;
      for (i = 0; i < RECT_W * RECT_H; i++) begin
         pick = $urandom_range(0, 9);
         scene[i] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      end
   endfunction

   // Mostly a still scene with noise of the chosen spread; some words stray
   // wildly and some positions change for good
   function automatic logic [PIX_W-1:0] frame_pixel();
      int idx, roll, v;
      idx  = (board.row % RECT_H) * RECT_W + (board.column % RECT_W);
      roll = $urandom_range(0, 99);
      if (roll < 6) return 8'($urandom_range(0, 255));
      if (roll < 10) scene[idx] = 8'($urandom_range(0, 255));
      v = int'(scene[idx]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // Setup cycle, then access cycle until pready
   task automatic csr_write(reg_index_type idx, int unsigned value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.write_register(idx, value);
   endtask

   task automatic configure(bit en, int unsigned thr, int unsigned w, int unsigned h);
      csr_write(REG_ENABLE, 32'(en));
      csr_write(REG_THRESHOLD, thr);
      csr_write(REG_WIDTH, w);
      csr_write(REG_HEIGHT, h);
   endtask

   // Hold valid high across back-to-back words; drop it only for a gap
   task automatic send_pixel(logic [PIX_W-1:0] pix);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(pix);
      pixels_sent++;
   endtask

   task automatic finish_frame();
      int unsigned n;
      n = board.pixels_to_frame_end();
      repeat (n) send_pixel(frame_pixel());
   endtask

   // Stop sending and wait for every outstanding word
   task automatic drain();
      req_valid <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
   endtask

   // Result side: random back-pressure, check every accepted word
   initial begin
      int unsigned gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_word(rsp_pixel_out, rsp_frames_averaged, rsp_frame_end);
      end
   end

   initial begin
      bit          en;
      int unsigned thr, w, h, part, start, phase, pick;
      board = new();
      new_scene();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pass-through after reset at the default size, field extremes
      send_pixel(8'h00);
      send_pixel(8'hFF);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      send_pixel(8'h01);
      send_pixel(8'h80);
      drain();

      // Zero size counts as one; the shrink ends line and frame at once
      csr_write(REG_WIDTH, 0);
      csr_write(REG_HEIGHT, 0);
      send_pixel(8'h7F);
      send_pixel(8'hFE);
      drain();

      // Oversize counts as the maximum
      csr_write(REG_WIDTH, 2047);
      csr_write(REG_HEIGHT, 2047);
      repeat (3) send_pixel(frame_pixel());
      drain();

      // Tallest frame, cut short by lowering the height below the current row
      csr_write(REG_WIDTH, 1);
      csr_write(REG_HEIGHT, MAX_HEIGHT);
      repeat (3) send_pixel(frame_pixel());
      drain();
      csr_write(REG_HEIGHT, 2);
      send_pixel(frame_pixel());
      drain();

      // Warm-up: fill every history slot over the whole rectangle
      start  = pixels_sent;
      spread = 3;
      configure(1'b1, 10, RECT_W, RECT_H);
      repeat (SLOTS) finish_frame();
      drain();

      // Random phases over sizes inside the rectangle
      phase = 0;
      while (pixels_sent - start < 450) begin
         en = (phase < 2) ? 1'b1 : ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 5);
         if (phase == 0) thr = 0;
         else if (phase == 1) thr = 255;
         else thr = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 40);
         w = $urandom_range(0, RECT_W);
         h = $urandom_range(0, RECT_H);
         configure(en, thr, w, h);
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = thr / 2;
            2: spread = (thr > 60) ? 60 : thr + 2;
            default: spread = $urandom_range(0, 60);
         endcase
         if ($urandom_range(0, 3) == 0) new_scene();
         repeat ($urandom_range(1, 3)) finish_frame();

         // Part of a frame, then change enable and size mid-frame
         if ($urandom_range(0, 2) == 0) begin
            part = board.pixels_to_frame_end();
            if (part > 1) repeat ($urandom_range(1, part - 1)) send_pixel(frame_pixel());
            drain();
            csr_write(REG_ENABLE, $urandom_range(0, 1));
            csr_write(REG_WIDTH, $urandom_range(0, RECT_W));
            csr_write(REG_HEIGHT, $urandom_range(0, RECT_H));
            finish_frame();
         end
         drain();
         phase++;
      end

      // Settle, then allow for any stray words
      steady = 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (board.failures == 0 && board.waiting() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
